### rtl/core/sdv_pkg.sv
package sdv_pkg;

  // Field widths of the items.
  localparam int unsigned CntW  = 16;
  localparam int unsigned SumW  = 32;
  localparam int unsigned SqW   = 47;
  localparam int unsigned OutW  = 32;

  // Internal widths.
  localparam int unsigned FracW = 16;
  localparam int unsigned NumW  = CntW + SqW;      // n*Q and the clamped numerator
  localparam int unsigned MagW  = SumW - 1;        // largest magnitude is 2^31
  localparam int unsigned D1W   = 2 * CntW;        // n*(n-1)
  localparam int unsigned DvsW  = 3 * CntW;        // n*n*(n-1)
  localparam int unsigned DvdW  = NumW + 2 * FracW; // numerator scaled by 2^32
  localparam int unsigned QuoW  = 64;
  localparam int unsigned RootW = QuoW / 2;
  localparam int unsigned SqRemW = RootW + 1;

  // Number of cells in each chain.
  localparam int unsigned DivCells  = DvdW;
  localparam int unsigned SqrtCells = RootW;

  typedef struct packed {
    logic [CntW-1:0]        sample_count;
    logic signed [SumW-1:0] sample_sum;
    logic [SqW-1:0]         square_sum;
  } in_item_t;

  typedef struct packed {
    logic [OutW-1:0] sample_sdev;
    logic [OutW-1:0] mean_serr;
    logic            not_available;
  } out_item_t;

  // One divider lane: divisor, partial remainder, quotient and overflow flag.
  typedef struct packed {
    logic [DvsW-1:0] dvs;
    logic [DvsW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            ovf;
  } div_lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  na;
    logic [DvdW-1:0]       dvd;
    div_lane_t [1:0]       lane;
  } div_stage_t;

  // One square-root lane: radicand bits still to use, remainder, root.
  typedef struct packed {
    logic [QuoW-1:0]   rad;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
    logic              ovf;
  } sqrt_lane_t;

  typedef struct packed {
    logic             valid;
    logic             na;
    sqrt_lane_t [1:0] lane;
  } sqrt_stage_t;

endpackage

### rtl/core/sdv_front.sv
module sdv_front
  import sdv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  in_item_t   item_i,
  output div_stage_t stage_o
);

  logic            v1_q, na1_q;
  logic [NumW-1:0] a_q;
  logic [NumW-1:0] b_q;
  logic [D1W-1:0]  d1_q;
  logic [CntW-1:0] n1_q;
  logic [MagW:0]   mag;
  logic [SumW-1:0] neg_sum;

  logic            v2_q, na2_q;
  logic [NumW-1:0] num_q;
  logic [D1W-1:0]  d1b_q;
  logic [DvsW-1:0] d2_q;

  // Magnitude of the signed sum.
  assign neg_sum = SumW'(~item_i.sample_sum) + SumW'(1);
  assign mag     = item_i.sample_sum[SumW-1] ? neg_sum : item_i.sample_sum;

  // First stage: the three products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na1_q <= item_i.sample_count < CntW'(2);
      n1_q  <= item_i.sample_count;
      a_q   <= NumW'(item_i.sample_count * item_i.square_sum);
      b_q   <= NumW'(mag * mag);
      d1_q  <= D1W'(item_i.sample_count * (item_i.sample_count - CntW'(1)));
    end
  end

  // Second stage: clamped numerator and the second divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na2_q <= na1_q;
      num_q <= (a_q > b_q) ? (a_q - b_q) : '0;
      d1b_q <= d1_q;
      d2_q  <= DvsW'(d1_q * n1_q);
    end
  end

  always_comb begin
    stage_o.valid        = v2_q;
    stage_o.na           = na2_q;
    stage_o.dvd          = {num_q, {(2*FracW){1'b0}}};
    stage_o.lane[0].dvs  = DvsW'(d1b_q);
    stage_o.lane[1].dvs  = d2_q;
    for (int l = 0; l < 2; l++) begin
      stage_o.lane[l].rem = '0;
      stage_o.lane[l].quo = '0;
      stage_o.lane[l].ovf = 1'b0;
    end
  end

endmodule

### rtl/core/sdv_div_cell.sv
module sdv_div_cell
  import sdv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  div_stage_t stage_d, stage_q;

  // One restoring division step per lane on the next dividend bit.
  always_comb begin
    logic [DvsW:0] t;
    logic [DvsW:0] diff;
    logic          ge;
    stage_d     = stage_i;
    stage_d.dvd = stage_i.dvd << 1;
    for (int l = 0; l < 2; l++) begin
      t    = {stage_i.lane[l].rem, stage_i.dvd[DvdW-1]};
      diff = t - {1'b0, stage_i.lane[l].dvs};
      ge   = t >= {1'b0, stage_i.lane[l].dvs};
      stage_d.lane[l].rem = ge ? diff[DvsW-1:0] : t[DvsW-1:0];
      stage_d.lane[l].quo = {stage_i.lane[l].quo[QuoW-2:0], ge};
      stage_d.lane[l].ovf = stage_i.lane[l].ovf | stage_i.lane[l].quo[QuoW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### rtl/core/sdv_sqrt_cell.sv
module sdv_sqrt_cell
  import sdv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  sqrt_stage_t stage_i,
  output sqrt_stage_t stage_o
);

  sqrt_stage_t stage_d, stage_q;

  // One root digit per lane from the next two radicand bits.
  always_comb begin
    logic [SqRemW+1:0] t;
    logic [SqRemW+1:0] trial;
    logic [SqRemW+1:0] diff;
    logic              ge;
    stage_d = stage_i;
    for (int l = 0; l < 2; l++) begin
      t     = {stage_i.lane[l].rem, stage_i.lane[l].rad[QuoW-1:QuoW-2]};
      trial = {1'b0, stage_i.lane[l].root, 2'b01};
      diff  = t - trial;
      ge    = t >= trial;
      stage_d.lane[l].rem  = ge ? diff[SqRemW-1:0] : t[SqRemW-1:0];
      stage_d.lane[l].root = {stage_i.lane[l].root[RootW-2:0], ge};
      stage_d.lane[l].rad  = stage_i.lane[l].rad << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### rtl/core/std_dev_and_err_from_sums.sv
// Sample standard deviation and standard error of the mean from moments.
//
// Input channel: in_valid_i, in_stall_o and in_item_i carry a sample count,
// the sum of the samples and the sum of their squares. Output channel:
// out_valid_o, out_stall_i and out_item_o carry both results as unsigned
// Q16.16 values, truncated, plus a not-available flag for counts below two.
// An item moves at a clock edge where valid is high and stall is low.
//
// Every item passes through the multiplier stages of sdv_front, a chain of
// 95 divider cells that each retire one quotient bit, a chain of 32
// square-root cells that each retire one root bit, and the output register.
// One item is accepted every cycle while no result is stalled at the output.
//
// When the output is stalled while holding an item, the whole chain holds
// and in_stall_o is raised. Reset clears all valid flags; no state is kept
// between items.
module std_dev_and_err_from_sums
  import sdv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic        advance;
  div_stage_t  div_st [DivCells+1];
  sqrt_stage_t sq_st  [SqrtCells+1];
  logic        out_valid_q;
  out_item_t   out_item_q;
  logic [OutW-1:0] res [2];

  // The chain moves unless a held result is stalled.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  sdv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .stage_o (div_st[0])
  );

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    sdv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .stage_i (div_st[i]),
      .stage_o (div_st[i+1])
    );
  end

  // Quotients enter the root chain.
  always_comb begin
    sq_st[0].valid = div_st[DivCells].valid;
    sq_st[0].na    = div_st[DivCells].na;
    for (int l = 0; l < 2; l++) begin
      sq_st[0].lane[l].rad  = div_st[DivCells].lane[l].quo;
      sq_st[0].lane[l].rem  = '0;
      sq_st[0].lane[l].root = '0;
      sq_st[0].lane[l].ovf  = div_st[DivCells].lane[l].ovf;
    end
  end

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    sdv_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .stage_i (sq_st[i]),
      .stage_o (sq_st[i+1])
    );
  end

  // Saturate on quotient overflow, zero when not available.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (sq_st[SqrtCells].na) begin
        res[l] = '0;
      end else if (sq_st[SqrtCells].lane[l].ovf) begin
        res[l] = '1;
      end else begin
        res[l] = sq_st[SqrtCells].lane[l].root;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= sq_st[SqrtCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.sample_sdev   <= res[0];
      out_item_q.mean_serr     <= res[1];
      out_item_q.not_available <= sq_st[SqrtCells].na;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // A not-available result carries zero values.
  a_na_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.not_available |->
      out_item_o.sample_sdev == '0 && out_item_o.mean_serr == '0)
    else $error("not-available result with nonzero values");

  // Input is held back only while a result is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a stalled result");

  // A stalled result is not dropped.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result was lost");
`endif

endmodule
